### hdl/polyphonic_click_track_generator_macros.svh
// Assertion macros for the click track generator checker.
// Depends on nothing; included by the checker file only.
`ifndef POLYPHONIC_CLICK_TRACK_GENERATOR_MACROS_SVH
`define POLYPHONIC_CLICK_TRACK_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCTG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pctg check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCTG_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pctg check failed");

`endif

### hdl/pctg_pkg.sv
// Package for the click track generator: sizes, register indexes and state codes.
// Depends on nothing; used by the interfaces, the top level and the checker.
package pctg_pkg;

    // Sizes of the design.
    localparam int VOICES        = 4;
    localparam int WAVE_DEPTH    = 8192;
    localparam int INTERVAL_BITS = 20;

    // Field widths.
    localparam int WAVE_AW  = $clog2(WAVE_DEPTH);
    localparam int SAMPLE_W = 16;
    localparam int VOLUME_W = 16;
    localparam int LEN_W    = 14;
    localparam int STEP_W   = INTERVAL_BITS + 1;
    localparam int OUT_W    = 18;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 21;

    // Voice indexing.
    localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCNT_W   = $clog2(VOICES + 1);

    // Mixing widths: Q1.15 sample times unsigned Q1.15 gain, then a sum of voices.
    localparam int PROD_W   = SAMPLE_W + VOLUME_W + 1;
    localparam int ACC_W    = PROD_W + VCNT_W;
    localparam int FRAC_W   = 15;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        CFG_VOLUME          = 3'd0,
        CFG_WAVE_LENGTH     = 3'd1,
        CFG_START_INTERVAL  = 3'd2,
        CFG_TARGET_INTERVAL = 3'd3,
        CFG_RAMP_STEP       = 3'd4
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_BEAT,
        S_MIX,
        S_DONE
    } seq_state_t;

endpackage

### hdl/pctg_if.sv
// Valid/ready channel interfaces: input items, output samples and register writes.
// Depends on pctg_pkg for field widths.
interface pctg_item_if;
    import pctg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic                       run;
    logic                       rolling;
    logic [WAVE_AW-1:0]         wave_index;
    logic signed [SAMPLE_W-1:0] wave_value;

    modport source (output valid, action, run, rolling, wave_index, wave_value,
                    input ready);
    modport sink   (input valid, action, run, rolling, wave_index, wave_value,
                    output ready);
endinterface

interface pctg_sample_if;
    import pctg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

interface pctg_cfg_if;
    import pctg_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/polyphonic_click_track_generator.sv
// Click track generator top level: beat timing, voice allocation, wave memory and mixer.
// Depends on pctg_pkg and the channel interfaces in pctg_if.sv.
//
//   channel   dir  word                                          handshake
//   items     in   action, run, rolling, wave_index, wave_value  valid/ready
//   results   out  sample_out                                    valid/ready
//   cfg       in   index, data                                   valid/ready, ready always high
//
// A wave write is taken while idle and leaves the sequencer idle. A stopped tick moves
// the sequencer to its final state, which loads the output register and returns to idle.
// A running tick passes through the beat state; the mix state then issues one wave memory
// read per voice and drains the read, multiply and accumulate stages, and the final state
// loads the output register. The next word is taken once the sequencer is idle again.
// Reset leaves the wave memory unwritten; no clearing pass is run.
// A result waiting on results.ready holds only the sequencer in its final state.
module polyphonic_click_track_generator (
    input  logic           clk,
    input  logic           rst_n,
    pctg_item_if.sink      items,
    pctg_sample_if.source  results,
    pctg_cfg_if.sink       cfg
);
    import pctg_pkg::*;

    localparam int IB = INTERVAL_BITS;
    localparam logic signed [IB+1:0] INT_MAX = $signed({2'b00, {IB{1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // Configuration registers.
    logic [VOLUME_W-1:0]     volume_reg;
    logic [LEN_W-1:0]        wave_len_reg;
    logic [IB-1:0]           start_int_reg;
    logic [IB-1:0]           target_int_reg;
    logic signed [STEP_W-1:0] ramp_step_reg;

    // Beat and voice state.
    seq_state_t               state_reg, state_next;
    logic                     running_reg, running_next;
    logic [IB-1:0]            interval_reg, interval_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [IB-1:0]            countdown_reg, countdown_next;
    logic                     voice_active_reg [VOICES];
    logic                     voice_active_next [VOICES];
    logic [WAVE_AW-1:0]       voice_pos_reg [VOICES];
    logic [WAVE_AW-1:0]       voice_pos_next [VOICES];
    logic [LEN_W-1:0]         voice_rem_reg [VOICES];
    logic [LEN_W-1:0]         voice_rem_next [VOICES];

    // Mixer pipeline.
    logic [VCNT_W-1:0]        issue_cnt_reg, issue_cnt_next;
    logic                     p1_valid_reg, p1_valid_next;
    logic                     p1_act_reg, p1_act_next;
    logic                     p2_valid_reg, p2_valid_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  out_data_reg, out_data_next;

    // Wave memory.
    logic signed [SAMPLE_W-1:0] click_wave [WAVE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [WAVE_AW-1:0]         rd_addr;

    // Control strobes.
    logic              in_fire;
    logic              mem_we;
    logic              issue_en;
    logic              issue_done;
    logic              out_load;
    logic [VOICE_W-1:0] vi;

    // Beat arithmetic.
    logic signed [IB+1:0] beat_sum;
    logic signed [IB+1:0] beat_tgt;
    logic signed [IB+1:0] beat_new;
    logic                 step_pos;
    logic                 step_neg;
    logic                 alloc_done;
    logic signed [ACC_W-1:0] acc_shift;

    assign in_fire    = items.valid && items.ready;
    assign issue_done = (issue_cnt_reg == VCNT_W'(VOICES));
    assign vi         = issue_cnt_reg[VOICE_W-1:0];
    assign cfg.ready  = 1'b1;

    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_data_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= VOLUME_W'(32768);
            wave_len_reg   <= '0;
            start_int_reg  <= IB'(24000);
            target_int_reg <= IB'(24000);
            ramp_step_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_VOLUME:          volume_reg     <= cfg.data[VOLUME_W-1:0];
                CFG_WAVE_LENGTH:     wave_len_reg   <= cfg.data[LEN_W-1:0];
                CFG_START_INTERVAL:  start_int_reg  <= cfg.data[IB-1:0];
                CFG_TARGET_INTERVAL: target_int_reg <= cfg.data[IB-1:0];
                CFG_RAMP_STEP:       ramp_step_reg  <= $signed(cfg.data[STEP_W-1:0]);
                default:             ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !items.action)
                begin
                    state_next = (items.run && items.rolling) ? S_BEAT : S_DONE;
                end
            end
            S_BEAT:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (issue_done && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        items.ready = 1'b0;
        issue_en    = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:  items.ready = 1'b1;
            S_BEAT:  ;
            S_MIX:   issue_en = !issue_done;
            S_DONE:  out_load = !out_valid_reg || results.ready;
            default: ;
        endcase
        mem_we = in_fire && items.action;
    end

    // Interval ramp for a firing beat, clipped at the target and then to range.
    always_comb
    begin
        beat_sum = $signed({2'b00, interval_reg}) + $signed({step_reg[STEP_W-1], step_reg});
        beat_tgt = $signed({2'b00, target_int_reg});
        step_pos = !step_reg[STEP_W-1] && (step_reg != '0);
        step_neg = step_reg[STEP_W-1];
        beat_new = beat_sum;
        if ((step_pos && (beat_sum > beat_tgt)) || (step_neg && (beat_sum < beat_tgt)))
        begin
            beat_new = beat_tgt;
        end
        if (beat_new < 0)
        begin
            beat_new = '0;
        end
        else if (beat_new > INT_MAX)
        begin
            beat_new = INT_MAX;
        end
    end

    // Floor shift of the mix, saturated in the output stage.
    assign acc_shift = acc_reg >>> FRAC_W;

    // Datapath next values.
    always_comb
    begin
        running_next   = running_reg;
        interval_next  = interval_reg;
        step_next      = step_reg;
        countdown_next = countdown_reg;
        for (int v = 0; v < VOICES; v++)
        begin
            voice_active_next[v] = voice_active_reg[v];
            voice_pos_next[v]    = voice_pos_reg[v];
            voice_rem_next[v]    = voice_rem_reg[v];
        end
        issue_cnt_next = issue_cnt_reg;
        p1_valid_next  = issue_en;
        p1_act_next    = 1'b0;
        p2_valid_next  = p1_valid_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = voice_pos_reg[vi];
        alloc_done     = 1'b0;

        // A tick either stops the metronome or (re)starts and then runs it.
        if (state_reg == S_IDLE && in_fire && !items.action)
        begin
            issue_cnt_next = '0;
            acc_next       = '0;
            if (!(items.run && items.rolling))
            begin
                running_next = 1'b0;
            end
            else if (!running_reg)
            begin
                running_next   = 1'b1;
                countdown_next = '0;
                interval_next  = start_int_reg;
                step_next      = ramp_step_reg;
                for (int v = 0; v < VOICES; v++)
                begin
                    voice_active_next[v] = 1'b0;
                end
            end
        end

        // Beat fires on a zero countdown and, with a nonzero wave length, starts the first free voice.
        if (state_reg == S_BEAT && countdown_reg == '0)
        begin
            interval_next  = beat_new[IB-1:0];
            countdown_next = beat_new[IB-1:0];
            if ((step_pos && (beat_sum > beat_tgt)) || (step_neg && (beat_sum < beat_tgt)))
            begin
                step_next = '0;
            end
            if (wave_len_reg != '0)
            begin
                for (int v = 0; v < VOICES; v++)
                begin
                    if (!alloc_done && !voice_active_reg[v])
                    begin
                        alloc_done           = 1'b1;
                        voice_active_next[v] = 1'b1;
                        voice_pos_next[v]    = '0;
                        voice_rem_next[v]    = wave_len_reg;
                    end
                end
            end
        end

        // Issue one voice read per cycle and advance that voice.
        if (issue_en)
        begin
            issue_cnt_next = issue_cnt_reg + VCNT_W'(1);
            p1_act_next    = voice_active_reg[vi];
            if (voice_active_reg[vi])
            begin
                voice_pos_next[vi]    = voice_pos_reg[vi] + WAVE_AW'(1);
                voice_rem_next[vi]    = voice_rem_reg[vi] - LEN_W'(1);
                voice_active_next[vi] = (voice_rem_reg[vi] != LEN_W'(1));
            end
        end

        // Multiply stage, then accumulate stage. The product stays a signed
        // expression so that negative wave samples are sign extended.
        if (p1_valid_reg)
        begin
            if (p1_act_reg)
            begin
                prod_next = rd_data_reg * $signed({1'b0, volume_reg});
            end
            else
            begin
                prod_next = '0;
            end
        end
        if (p2_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        // Countdown moves once per running tick, after the mix.
        if (state_reg == S_MIX && state_next == S_DONE)
        begin
            countdown_next = countdown_reg - IB'(1);
        end

        // Output register.
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (acc_shift > SAT_HI)
            begin
                out_data_next = SAT_HI[OUT_W-1:0];
            end
            else if (acc_shift < SAT_LO)
            begin
                out_data_next = SAT_LO[OUT_W-1:0];
            end
            else
            begin
                out_data_next = acc_shift[OUT_W-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= 1'b0;
            interval_reg  <= '0;
            step_reg      <= '0;
            countdown_reg <= '0;
            issue_cnt_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_active_reg[v] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            interval_reg  <= interval_next;
            step_reg      <= step_next;
            countdown_reg <= countdown_next;
            issue_cnt_reg <= issue_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_active_reg[v] <= voice_active_next[v];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        p1_act_reg   <= p1_act_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        for (int v = 0; v < VOICES; v++)
        begin
            voice_pos_reg[v] <= voice_pos_next[v];
            voice_rem_reg[v] <= voice_rem_next[v];
        end
    end

    // Wave memory: writes only while idle; the read runs every cycle but its data is used
    // only while mixing, so no read that is used meets a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            click_wave[items.wave_index] <= items.wave_value;
        end
        rd_data_reg <= click_wave[rd_addr];
    end

endmodule

### hdl/pctg_checker.sv
// Port-level checker for the click track generator, bound to the top level.
// Depends on pctg_pkg and polyphonic_click_track_generator_macros.svh.
`include "polyphonic_click_track_generator_macros.svh"

module pctg_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           in_action,
    input logic                           in_run,
    input logic                           in_rolling,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [pctg_pkg::OUT_W-1:0] sample_out
);

    // A waiting word stays offered and unchanged.
    `PCTG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PCTG_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(sample_out))

    // A wave write never produces a word.
    `PCTG_ASSERT_NXT(a_write_silent, clk, rst_n, in_valid && in_ready && in_action && !out_valid, !out_valid)

    // A tick with run or rolling clear yields a zero word.
    `PCTG_ASSERT_IMP(a_stop_zero, clk, rst_n, in_valid && in_ready && !in_action && !(in_run && in_rolling) && !out_valid, ##2 (out_valid && sample_out == '0))

endmodule

bind polyphonic_click_track_generator pctg_checker u_pctg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .in_action  (items.action),
    .in_run     (items.run),
    .in_rolling (items.rolling),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .sample_out (results.sample_out)
);

### tb/polyphonic_click_track_generator_tb.sv
// Self-checking bench for the click track generator: directed and random ticks, wave
// writes and register phases, every output sample checked against a local predictor.
// Depends on pctg_pkg, the channel interfaces in pctg_if.sv and the top level RTL.
module polyphonic_click_track_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pctg_pkg::*;

    // Word kinds on the item channel.
    localparam bit ACT_TICK  = 1'b0;
    localparam bit ACT_WRITE = 1'b1;

    // Bench sizes and limits.
    localparam int     WAVE_PRELOAD = 48;
    localparam int     MAX_WAIT     = 17;
    localparam int     DRAIN_CYCLES = VOICES + 12;
    localparam int     LONG_HOLD    = 400;
    localparam int     ITEM_TARGET  = 1750;
    localparam int     GAIN_UNITY   = 32768;
    localparam int     MAX_INTERVAL = (1 << INTERVAL_BITS) - 1;
    localparam longint SAMPLE_MIN   = -(longint'(1) << (OUT_W - 1));
    localparam longint SAMPLE_MAX   = (longint'(1) << (OUT_W - 1)) - 1;

    typedef struct {
        bit                         action;
        bit                         run;
        bit                         rolling;
        logic [WAVE_AW-1:0]         index;
        logic signed [SAMPLE_W-1:0] value;
    } click_word_t;

    logic clk;
    logic rst_n;

    pctg_item_if   item_ch ();
    pctg_sample_if sample_ch ();
    pctg_cfg_if    reg_ch ();

    polyphonic_click_track_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (sample_ch),
        .cfg     (reg_ch)
    );

    // Register copies, at their reset values.
    bit [VOLUME_W-1:0]        cfg_gain      = VOLUME_W'(GAIN_UNITY);
    bit [LEN_W-1:0]           cfg_click_len = '0;
    bit [INTERVAL_BITS-1:0]   cfg_start_iv  = INTERVAL_BITS'(24000);
    bit [INTERVAL_BITS-1:0]   cfg_target_iv = INTERVAL_BITS'(24000);
    bit signed [STEP_W-1:0]   cfg_ramp      = '0;

    // Predicted metronome state.
    bit                        pred_running;
    bit [INTERVAL_BITS-1:0]    pred_interval;
    bit signed [STEP_W-1:0]    pred_step;
    bit [INTERVAL_BITS-1:0]    pred_countdown;
    bit                        voice_on   [VOICES];
    bit [WAVE_AW-1:0]          voice_pos  [VOICES];
    bit [LEN_W-1:0]            voice_left [VOICES];
    bit signed [SAMPLE_W-1:0]  wave_shadow [WAVE_DEPTH];

    click_word_t               pending_words [$];
    logic signed [OUT_W-1:0]   expected_samples [$];
    click_word_t               on_bus;
    click_word_t               next_word;
    logic signed [OUT_W-1:0]   want;

    int words_queued;
    int mismatches;
    int send_wait;
    bit send_burst;
    int recv_wait;
    int recv_draw;
    bit recv_burst;
    int hold_requests;
    int hold_served;

    // Work out the sample that one tick word produces and advance the state.
    function automatic logic signed [OUT_W-1:0] next_mixed_sample(bit run_f, bit rolling_f);
        longint next_iv;
        longint acc;
        longint q;
        int     v;
        if (!run_f || !rolling_f) begin
            pred_running = 1'b0;
            return '0;
        end
        // A fresh start frees every voice and reloads the tempo state.
        if (!pred_running) begin
            pred_running = 1'b1;
            for (v = 0; v < VOICES; v++) voice_on[v] = 1'b0;
            pred_countdown = '0;
            pred_interval  = cfg_start_iv;
            pred_step      = cfg_ramp;
        end
        // The beat fires when the countdown reads zero.
        if (pred_countdown == 0) begin
            next_iv = longint'(pred_interval) + longint'(pred_step);
            if ((pred_step > 0 && next_iv > longint'(cfg_target_iv)) ||
                (pred_step < 0 && next_iv < longint'(cfg_target_iv))) begin
                next_iv   = longint'(cfg_target_iv);
                pred_step = '0;
            end
            if (next_iv < 0) next_iv = 0;
            if (next_iv > MAX_INTERVAL) next_iv = MAX_INTERVAL;
            pred_interval  = next_iv[INTERVAL_BITS-1:0];
            pred_countdown = next_iv[INTERVAL_BITS-1:0];
            // The first free voice takes the click; with none free the beat is missed.
            if (cfg_click_len != 0) begin
                for (v = 0; v < VOICES; v++) begin
                    if (!voice_on[v]) begin
                        voice_on[v]   = 1'b1;
                        voice_pos[v]  = '0;
                        voice_left[v] = cfg_click_len;
                        break;
                    end
                end
            end
        end
        // Mix the active voices, floor the sum of Q2.30 products to Q3.15 and saturate.
        acc = 0;
        for (v = 0; v < VOICES; v++) begin
            if (voice_on[v]) begin
                acc += longint'(wave_shadow[voice_pos[v]]) * longint'(cfg_gain);
                voice_pos[v]  = voice_pos[v] + 1'b1;
                voice_left[v] = voice_left[v] - 1'b1;
                if (voice_left[v] == 0) voice_on[v] = 1'b0;
            end
        end
        q = acc >>> FRAC_W;
        if (q < SAMPLE_MIN) q = SAMPLE_MIN;
        if (q > SAMPLE_MAX) q = SAMPLE_MAX;
        pred_countdown = pred_countdown - 1'b1;
        return q[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic push_tick(bit run_f, bit rolling_f);
        click_word_t w;
        w.action  = ACT_TICK;
        w.run     = run_f;
        w.rolling = rolling_f;
        w.index   = WAVE_AW'($urandom_range(0, WAVE_DEPTH - 1));
        w.value   = SAMPLE_W'($urandom);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_write(int idx, int val);
        click_word_t w;
        w.action  = ACT_WRITE;
        w.run     = 1'($urandom);
        w.rolling = 1'($urandom);
        w.index   = WAVE_AW'(idx);
        w.value   = SAMPLE_W'(val);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Wait until every word is taken and every sample is back, then let the pipe drain.
    task automatic settle();
        do @(negedge clk);
        while (pending_words.size() != 0 || item_ch.valid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t which, int value);
        @(posedge clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= which;
        reg_ch.data  <= CFG_DW'(value);
        do @(posedge clk);
        while (!reg_ch.ready);
        reg_ch.valid <= 1'b0;
        case (which)
            CFG_VOLUME:          cfg_gain      = VOLUME_W'(value);
            CFG_WAVE_LENGTH:     cfg_click_len = LEN_W'(value);
            CFG_START_INTERVAL:  cfg_start_iv  = INTERVAL_BITS'(value);
            CFG_TARGET_INTERVAL: cfg_target_iv = INTERVAL_BITS'(value);
            CFG_RAMP_STEP:       cfg_ramp      = STEP_W'(value);
            default: ;
        endcase
    endtask

    // Pick a new random register setting; wave lengths stay inside the loaded prefix.
    task automatic random_setup();
        int pick;
        if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 5);
            write_reg(CFG_VOLUME, (pick == 0) ? 0 :
                                  (pick == 1) ? GAIN_UNITY : $urandom_range(0, GAIN_UNITY));
        end
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_WAVE_LENGTH, ($urandom_range(0, 9) == 0) ? 0 :
                                       $urandom_range(1, WAVE_PRELOAD));
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_START_INTERVAL, ($urandom_range(0, 9) == 0) ?
                                          $urandom_range(1, MAX_INTERVAL) : $urandom_range(1, 30));
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_TARGET_INTERVAL, ($urandom_range(0, 9) == 0) ?
                                           $urandom_range(1, MAX_INTERVAL) : $urandom_range(1, 30));
        if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 9);
            write_reg(CFG_RAMP_STEP, (pick == 0) ?
                      int'($urandom_range(0, 2 * MAX_INTERVAL)) - MAX_INTERVAL :
                      int'($urandom_range(0, 12)) - 6);
        end
    endtask

    // Mostly running ticks, with stops and wave rewrites mixed in.
    task automatic random_phase(int n_words);
        int k;
        int r;
        for (k = 0; k < n_words; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_write(($urandom_range(0, 1) != 0) ? $urandom_range(0, WAVE_PRELOAD - 1) :
                                                         $urandom_range(0, WAVE_DEPTH - 1),
                           ($urandom_range(0, 7) == 0) ? -32768 : int'($urandom));
            end else if (r < 17) begin
                r = $urandom_range(0, 2);
                push_tick(r[0], r[1]);
            end else begin
                push_tick(1'b1, 1'b1);
            end
        end
    endtask

    // Clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Item driver: offers queued words with a random gap after each one (none in a burst)
    // and predicts each word as it is accepted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_ch.valid      <= 1'b0;
            item_ch.action     <= 1'b0;
            item_ch.run        <= 1'b0;
            item_ch.rolling    <= 1'b0;
            item_ch.wave_index <= '0;
            item_ch.wave_value <= '0;
            on_bus             <= '{default: '0};
            send_wait          <= 0;
            send_burst         <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                if (on_bus.action == ACT_WRITE)
                    wave_shadow[on_bus.index] = on_bus.value;
                else
                    expected_samples.push_back(next_mixed_sample(on_bus.run, on_bus.rolling));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (send_wait > 0) begin
                    send_wait     <= send_wait - 1;
                    item_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.action     <= next_word.action;
                    item_ch.run        <= next_word.run;
                    item_ch.rolling    <= next_word.rolling;
                    item_ch.wave_index <= next_word.index;
                    item_ch.wave_value <= next_word.value;
                    on_bus             <= next_word;
                    if ($urandom_range(0, 63) == 0) send_burst <= !send_burst;
                    send_wait <= send_burst ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Sample receiver: random stall after each word, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sample_ch.ready <= 1'b0;
            recv_wait       <= 0;
            recv_burst      <= 1'b0;
            hold_served     <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served     <= hold_requests;
            recv_wait       <= LONG_HOLD;
            sample_ch.ready <= 1'b0;
        end else if (sample_ch.valid && sample_ch.ready) begin
            if ($urandom_range(0, 63) == 0) recv_burst <= !recv_burst;
            recv_draw = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            recv_wait       <= recv_draw;
            sample_ch.ready <= (recv_draw == 0);
        end else if (recv_wait > 1) begin
            recv_wait       <= recv_wait - 1;
            sample_ch.ready <= 1'b0;
        end else begin
            recv_wait       <= 0;
            sample_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted sample word with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && sample_ch.valid && sample_ch.ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d with none expected", sample_ch.sample_out));
            end else begin
                want = expected_samples.pop_front();
                if (sample_ch.sample_out !== want)
                    report_mismatch($sformatf("sample_out %0d, expected %0d",
                                              sample_ch.sample_out, want));
            end
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        int i;
        int phase;
        rst_n              = 1'b0;
        reg_ch.valid       = 1'b0;
        reg_ch.index       = CFG_VOLUME;
        reg_ch.data        = '0;
        words_queued       = 0;
        mismatches         = 0;
        hold_requests      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Fast beats on a 16-sample click: all voices busy, missed beats, full-scale sums.
        write_reg(CFG_VOLUME, GAIN_UNITY);
        write_reg(CFG_WAVE_LENGTH, 16);
        write_reg(CFG_START_INTERVAL, 1);
        write_reg(CFG_TARGET_INTERVAL, 1);
        write_reg(CFG_RAMP_STEP, 0);

        // Load the wave prefix that clicks play from: negative then positive full scale.
        for (i = 0; i < WAVE_PRELOAD; i++)
            push_write(i, (i < 8) ? -32768 : (i < 16) ? 32767 : int'($urandom));
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        for (i = 0; i < 13; i++) push_tick(1'b1, 1'b1);
        push_write(WAVE_DEPTH - 1, 0);
        push_tick(1'b0, 1'b0);
        settle();

        // Steepest upward ramp, clipped at the top target; no click with zero length.
        write_reg(CFG_VOLUME, 0);
        write_reg(CFG_WAVE_LENGTH, 0);
        write_reg(CFG_TARGET_INTERVAL, MAX_INTERVAL);
        write_reg(CFG_RAMP_STEP, MAX_INTERVAL);
        for (i = 0; i < 3; i++) push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        settle();

        // Steepest downward ramp, clipped at a target interval of 1.
        write_reg(CFG_VOLUME, 1);
        write_reg(CFG_WAVE_LENGTH, 1);
        write_reg(CFG_START_INTERVAL, MAX_INTERVAL);
        write_reg(CFG_TARGET_INTERVAL, 1);
        write_reg(CFG_RAMP_STEP, -MAX_INTERVAL);
        for (i = 0; i < 3; i++) push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        settle();

        // Zero interval: the countdown wraps after the first beat.
        write_reg(CFG_VOLUME, GAIN_UNITY);
        write_reg(CFG_WAVE_LENGTH, 2);
        write_reg(CFG_START_INTERVAL, 0);
        write_reg(CFG_TARGET_INTERVAL, 0);
        write_reg(CFG_RAMP_STEP, 0);
        for (i = 0; i < 3; i++) push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        settle();

        // A click as long as the wave memory, cut short by a stop before it reads past the loaded prefix.
        write_reg(CFG_VOLUME, $urandom_range(1, GAIN_UNITY));
        write_reg(CFG_WAVE_LENGTH, WAVE_DEPTH);
        write_reg(CFG_START_INTERVAL, 7);
        write_reg(CFG_TARGET_INTERVAL, 7);
        push_tick(1'b0, 1'b1);
        for (i = 0; i < WAVE_PRELOAD - 8; i++) push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        settle();
        write_reg(CFG_WAVE_LENGTH, WAVE_PRELOAD);

        // Random phases; the first is long and the receiver holds off during it.
        phase = 0;
        while (words_queued < ITEM_TARGET) begin
            settle();
            random_setup();
            random_phase((phase == 0) ? 150 : $urandom_range(20, 80));
            if (phase == 0) hold_requests++;
            phase++;
        end
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
